[sv/gvi_pkg.sv]
// shared types, command codes and constants for the game value iteration block
package gvi_pkg;

  localparam int NUM_STATES_DEF      = 1024;
  localparam int NUM_CHOICES_DEF     = 4096;
  localparam int NUM_TRANSITIONS_DEF = 16384;

  localparam int FRAC_BITS = 31;
  localparam int SB_W      = 13;
  localparam int CB_W      = 15;
  localparam int VAL_W     = 32;
  localparam logic [VAL_W-1:0] FULL = VAL_W'(64'd1 << FRAC_BITS);

  localparam logic [31:0] PREC_RST  = 32'd2147;
  localparam logic [15:0] LIMIT_RST = 16'hFFFF;

  typedef enum logic [2:0] {
    CMD_SBOUND = 3'd0,
    CMD_CBOUND = 3'd1,
    CMD_TRANS  = 3'd2,
    CMD_INIT   = 3'd3,
    CMD_START  = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_REL   = 3'd0,
    CFG_PREC  = 3'd1,
    CFG_MAXC  = 3'd2,
    CFG_CNT   = 3'd3,
    CFG_LIMIT = 3'd4
  } cfg_e;

  typedef enum logic [4:0] {
    S_IDLE, S_SCHK, S_SB0, S_SB1, S_SB2, S_CCHK, S_CB0, S_CB1, S_CB2,
    S_TCHK, S_TV, S_MUL, S_ACC, S_CEND, S_OLD, S_DIFF, S_DIV, S_UPD,
    S_FIN, S_RDV
  } state_e;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [14:0] index;
    logic [14:0] bound;
    logic [9:0]  target;
    logic [31:0] weight;
    logic [31:0] value;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] value_out;
    logic        converged;
    logic [15:0] sweeps_done;
  } res_t;

  typedef struct packed {
    logic clr;
    logic mul;
    logic acc;
  } mac_ctrl_t;

endpackage

[sv/gvi_mac.sv]
// shared multiply and saturating accumulate unit for choice sums
module gvi_mac (
  input  logic                            clk_i,
  input  gvi_pkg::mac_ctrl_t              ctrl_i,
  input  logic [gvi_pkg::VAL_W-1:0]       weight_i,
  input  logic [gvi_pkg::VAL_W-1:0]       value_i,
  output logic [gvi_pkg::VAL_W-1:0]       acc_o
);

  logic [2*gvi_pkg::VAL_W-1:0] prod_q;
  logic [gvi_pkg::VAL_W-1:0]   acc_q, acc_d;
  logic [gvi_pkg::VAL_W:0]     prod_sh;
  logic [gvi_pkg::VAL_W-1:0]   prod_cap;
  logic [gvi_pkg::VAL_W:0]     sum;

  always_comb begin
    prod_sh  = (gvi_pkg::VAL_W+1)'(prod_q >> gvi_pkg::FRAC_BITS);
    prod_cap = (prod_sh > {1'b0, gvi_pkg::FULL}) ? gvi_pkg::FULL
                                                 : prod_sh[gvi_pkg::VAL_W-1:0];
    sum      = {1'b0, acc_q} + {1'b0, prod_cap};
    acc_d    = acc_q;
    if (ctrl_i.clr) begin
      acc_d = '0;
    end else if (ctrl_i.acc) begin
      acc_d = (sum > {1'b0, gvi_pkg::FULL}) ? gvi_pkg::FULL : sum[gvi_pkg::VAL_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul) begin
      prod_q <= weight_i * value_i;
    end
    acc_q <= acc_d;
  end

  assign acc_o = acc_q;

endmodule

[sv/gvi_div.sv]
// restoring divider for relative change, one quotient bit per cycle
module gvi_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] diff_i,
  input  logic [31:0] old_i,
  output logic        done_o,
  output logic [31:0] quot_o
);

  logic [31:0] rem_q, rem_d;
  logic [31:0] feed_q, feed_d;
  logic [31:0] quot_q, quot_d;
  logic [31:0] dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        run_q, run_d;
  logic        done_q, done_d;
  logic [32:0] trial;

  always_comb begin
    rem_d  = rem_q;
    feed_d = feed_q;
    quot_d = quot_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    trial  = {rem_q, feed_q[31]};
    if (start_i) begin
      rem_d  = {1'b0, diff_i[31:1]};
      feed_d = {diff_i[0], 31'd0};
      dvs_d  = old_i;
      cnt_d  = 6'd32;
      run_d  = 1'b1;
    end else if (run_q) begin
      feed_d = {feed_q[30:0], 1'b0};
      if (trial >= {1'b0, dvs_q}) begin
        rem_d  = 32'(trial - {1'b0, dvs_q});
        quot_d = {quot_q[30:0], 1'b1};
      end else begin
        rem_d  = trial[31:0];
        quot_d = {quot_q[30:0], 1'b0};
      end
      cnt_d = cnt_q - 6'd1;
      if (cnt_q == 6'd1) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    feed_q <= feed_d;
    quot_q <= quot_d;
    dvs_q  <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

[sv/game_value_iteration_gauss_seidel.sv]
// top level: game memories, sweep sequencer and configuration registers
// Command channel: a request is taken when start is high and busy is low.
// Load requests (state bound, choice bound, transition, initial value) are
// written in the accept cycle; busy stays low.
// A read request gives one result in the cycle after accept (memory read).
// A start request runs Gauss-Seidel sweeps over the states below the larger
// of the MAXC and CNT settings (each capped at NUM_STATES); busy stays high
// until the result. Relative mode divides by a nonzero old value unless the
// quotient saturates (the shared divider makes one quotient bit a cycle);
// the result follows in the cycle after the last sweep.
// The shared multiplier and accumulator run every transition.
// Results show on res_o for one cycle with done_o high; the receiver
// cannot stall, and no other request is taken while busy.
// Configuration writes use cfg_valid_i/cfg_ready_o, always ready, and are
// meant for idle periods. Reset restores register defaults and clears the
// sequencer; the memories are not cleared and hold whatever was loaded.
module game_value_iteration_gauss_seidel #(
  parameter int NUM_STATES      = gvi_pkg::NUM_STATES_DEF,
  parameter int NUM_CHOICES     = gvi_pkg::NUM_CHOICES_DEF,
  parameter int NUM_TRANSITIONS = gvi_pkg::NUM_TRANSITIONS_DEF
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  gvi_pkg::req_t req_i,
  output logic          done_o,
  output gvi_pkg::res_t res_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);

  localparam int SBAW = $clog2(NUM_STATES + 1);
  localparam int VAW  = $clog2(NUM_STATES);
  localparam int CBAW = $clog2(NUM_CHOICES + 1);
  localparam int TAW  = $clog2(NUM_TRANSITIONS);
  localparam int SW   = SBAW;
  localparam int CW   = (gvi_pkg::SB_W > CBAW) ? gvi_pkg::SB_W : CBAW;
  localparam int TW0  = $clog2(NUM_TRANSITIONS + 1);
  localparam int TW   = (gvi_pkg::CB_W > TW0) ? gvi_pkg::CB_W : TW0;

  logic [gvi_pkg::SB_W-1:0]  sb_mem [NUM_STATES+1];
  logic [gvi_pkg::CB_W-1:0]  cb_mem [NUM_CHOICES+1];
  logic [9:0]                tg_mem [NUM_TRANSITIONS];
  logic [31:0]               w_mem  [NUM_TRANSITIONS];
  logic [31:0]               v_mem  [NUM_STATES];

  gvi_pkg::state_e state_q, state_d;

  logic        rel_q;
  logic [31:0] prec_q;
  logic [10:0] maxc_q, cnt_q;
  logic [15:0] limit_q;

  logic [SW-1:0]  s_q, end_q, maxe_q;
  logic [CW-1:0]  c_q, hic_q;
  logic [TW-1:0]  t_q, hit_q;
  logic [31:0]    best_q, diff_q, largest_q;
  logic [15:0]    sweep_q;
  logic           conv_q, rd_ok_q;

  logic [gvi_pkg::SB_W-1:0] sb_rd_q;
  logic [gvi_pkg::CB_W-1:0] cb_rd_q;
  logic [9:0]               tg_rd_q;
  logic [31:0]              w_rd_q, v_rd_q;

  logic           accept;
  logic [31:0]    idx_ext, tg_ext;
  logic [SBAW-1:0] sb_ra;
  logic [CBAW-1:0] cb_ra;
  logic [VAW-1:0]  v_ra, v_wa;
  logic           v_we;
  logic [31:0]    v_wd;
  logic [SW-1:0]  s_inc;
  logic [CW-1:0]  c_inc;
  logic           maximize, tg_ok, conv, last_sweep, div_start, div_done, div_sat;
  logic [31:0]    diff_abs, quot, mac_acc;
  logic [15:0]    sweep_inc, limit_eff;
  logic [SW-1:0]  maxe_c, mine_c;
  gvi_pkg::mac_ctrl_t mac_ctrl;

  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign idx_ext     = 32'(req_i.index);
  assign tg_ext      = 32'(tg_rd_q);
  assign s_inc       = s_q + SW'(1);
  assign c_inc       = c_q + CW'(1);
  assign maximize    = s_q < maxe_q;
  assign tg_ok       = tg_ext < 32'(NUM_STATES);
  assign sweep_inc   = sweep_q + 16'd1;
  assign limit_eff   = (limit_q == 16'd0) ? 16'd1 : limit_q;
  assign conv        = {largest_q, 1'b0} <= {1'b0, prec_q};
  assign last_sweep  = conv || (sweep_inc >= limit_eff);
  assign diff_abs    = (best_q > v_rd_q) ? best_q - v_rd_q : v_rd_q - best_q;
  assign div_sat     = {1'b0, diff_abs} >= {v_rd_q, 1'b0};
  assign div_start   = (state_q == gvi_pkg::S_DIFF) && rel_q && (v_rd_q != 32'd0) && !div_sat;
  assign maxe_c      = (32'(maxc_q) > 32'(NUM_STATES)) ? SW'(NUM_STATES) : SW'(maxc_q);
  assign mine_c      = (32'(cnt_q) > 32'(NUM_STATES)) ? SW'(NUM_STATES) : SW'(cnt_q);

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rel_q   <= 1'b0;
      prec_q  <= gvi_pkg::PREC_RST;
      maxc_q  <= '0;
      cnt_q   <= '0;
      limit_q <= gvi_pkg::LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        gvi_pkg::CFG_REL:   rel_q   <= cfg_data_i[0];
        gvi_pkg::CFG_PREC:  prec_q  <= cfg_data_i;
        gvi_pkg::CFG_MAXC:  maxc_q  <= cfg_data_i[10:0];
        gvi_pkg::CFG_CNT:   cnt_q   <= cfg_data_i[10:0];
        gvi_pkg::CFG_LIMIT: limit_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      gvi_pkg::S_IDLE: begin
        if (accept && req_i.cmd == gvi_pkg::CMD_START) state_d = gvi_pkg::S_SCHK;
        else if (accept && req_i.cmd == gvi_pkg::CMD_READ) state_d = gvi_pkg::S_RDV;
      end
      gvi_pkg::S_SCHK: begin
        if (s_q >= end_q) state_d = last_sweep ? gvi_pkg::S_FIN : gvi_pkg::S_SCHK;
        else state_d = gvi_pkg::S_SB0;
      end
      gvi_pkg::S_SB0:  state_d = gvi_pkg::S_SB1;
      gvi_pkg::S_SB1:  state_d = gvi_pkg::S_SB2;
      gvi_pkg::S_SB2:  state_d = gvi_pkg::S_CCHK;
      gvi_pkg::S_CCHK: state_d = (c_q >= hic_q) ? gvi_pkg::S_OLD : gvi_pkg::S_CB0;
      gvi_pkg::S_CB0:  state_d = gvi_pkg::S_CB1;
      gvi_pkg::S_CB1:  state_d = gvi_pkg::S_CB2;
      gvi_pkg::S_CB2:  state_d = gvi_pkg::S_TCHK;
      gvi_pkg::S_TCHK: state_d = (t_q >= hit_q) ? gvi_pkg::S_CEND : gvi_pkg::S_TV;
      gvi_pkg::S_TV:   state_d = gvi_pkg::S_MUL;
      gvi_pkg::S_MUL:  state_d = gvi_pkg::S_ACC;
      gvi_pkg::S_ACC:  state_d = gvi_pkg::S_TCHK;
      gvi_pkg::S_CEND: state_d = gvi_pkg::S_CCHK;
      gvi_pkg::S_OLD:  state_d = gvi_pkg::S_DIFF;
      gvi_pkg::S_DIFF: state_d = div_start ? gvi_pkg::S_DIV : gvi_pkg::S_UPD;
      gvi_pkg::S_DIV:  state_d = div_done ? gvi_pkg::S_UPD : gvi_pkg::S_DIV;
      gvi_pkg::S_UPD:  state_d = gvi_pkg::S_SCHK;
      gvi_pkg::S_FIN:  state_d = gvi_pkg::S_IDLE;
      gvi_pkg::S_RDV:  state_d = gvi_pkg::S_IDLE;
      default:         state_d = gvi_pkg::S_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy     = state_q != gvi_pkg::S_IDLE;
    done_o   = (state_q == gvi_pkg::S_FIN) || (state_q == gvi_pkg::S_RDV);
    res_o    = '0;
    if (state_q == gvi_pkg::S_RDV) begin
      res_o.kind      = 1'b1;
      res_o.value_out = rd_ok_q ? v_rd_q : 32'd0;
    end else begin
      res_o.converged   = conv_q;
      res_o.sweeps_done = sweep_q;
    end
    sb_ra    = (state_q == gvi_pkg::S_SB1) ? s_inc : s_q;
    cb_ra    = (state_q == gvi_pkg::S_CB1) ? c_inc[CBAW-1:0] : c_q[CBAW-1:0];
    case (state_q)
      gvi_pkg::S_IDLE: v_ra = idx_ext[VAW-1:0];
      gvi_pkg::S_TV:   v_ra = tg_ext[VAW-1:0];
      default:         v_ra = s_q[VAW-1:0];
    endcase
    v_we = 1'b0;
    v_wa = s_q[VAW-1:0];
    v_wd = best_q;
    if (state_q == gvi_pkg::S_UPD) begin
      v_we = 1'b1;
    end else if (accept && req_i.cmd == gvi_pkg::CMD_INIT && idx_ext < 32'(NUM_STATES)) begin
      v_we = 1'b1;
      v_wa = idx_ext[VAW-1:0];
      v_wd = req_i.value;
    end
    mac_ctrl.clr = state_q == gvi_pkg::S_CB2;
    mac_ctrl.mul = state_q == gvi_pkg::S_MUL;
    mac_ctrl.acc = state_q == gvi_pkg::S_ACC;
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (accept && req_i.cmd == gvi_pkg::CMD_SBOUND && idx_ext <= 32'(NUM_STATES)) begin
      sb_mem[idx_ext[SBAW-1:0]] <= req_i.bound[gvi_pkg::SB_W-1:0];
    end
    sb_rd_q <= sb_mem[sb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.cmd == gvi_pkg::CMD_CBOUND && idx_ext <= 32'(NUM_CHOICES)) begin
      cb_mem[idx_ext[CBAW-1:0]] <= req_i.bound;
    end
    cb_rd_q <= cb_mem[cb_ra];
  end

  always_ff @(posedge clk_i) begin
    if (accept && req_i.cmd == gvi_pkg::CMD_TRANS && idx_ext < 32'(NUM_TRANSITIONS)) begin
      tg_mem[idx_ext[TAW-1:0]] <= req_i.target;
      w_mem[idx_ext[TAW-1:0]]  <= req_i.weight;
    end
    tg_rd_q <= tg_mem[t_q[TAW-1:0]];
    w_rd_q  <= w_mem[t_q[TAW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      v_mem[v_wa] <= v_wd;
    end
    v_rd_q <= v_mem[v_ra];
  end

  // sequencer state and counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= gvi_pkg::S_IDLE;
      largest_q <= '0;
      sweep_q   <= '0;
      conv_q    <= 1'b0;
      rd_ok_q   <= 1'b0;
      s_q       <= '0;
      end_q     <= '0;
      maxe_q    <= '0;
      c_q       <= '0;
      hic_q     <= '0;
      t_q       <= '0;
      hit_q     <= '0;
      best_q    <= '0;
      diff_q    <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        gvi_pkg::S_IDLE: begin
          rd_ok_q <= idx_ext < 32'(NUM_STATES);
          if (accept && req_i.cmd == gvi_pkg::CMD_START) begin
            s_q       <= '0;
            maxe_q    <= maxe_c;
            end_q     <= (maxe_c > mine_c) ? maxe_c : mine_c;
            largest_q <= '0;
            sweep_q   <= '0;
          end
        end
        gvi_pkg::S_SCHK: begin
          if (s_q >= end_q) begin
            sweep_q   <= sweep_inc;
            conv_q    <= conv;
            s_q       <= '0;
            if (!last_sweep) largest_q <= '0;
          end
        end
        gvi_pkg::S_SB1: c_q <= CW'(sb_rd_q);
        gvi_pkg::S_SB2: begin
          hic_q  <= (32'(sb_rd_q) > 32'(NUM_CHOICES)) ? CW'(NUM_CHOICES) : CW'(sb_rd_q);
          best_q <= maximize ? 32'd0 : gvi_pkg::FULL;
        end
        gvi_pkg::S_CB1: t_q <= TW'(cb_rd_q);
        gvi_pkg::S_CB2: begin
          hit_q <= (32'(cb_rd_q) > 32'(NUM_TRANSITIONS)) ? TW'(NUM_TRANSITIONS)
                                                         : TW'(cb_rd_q);
        end
        gvi_pkg::S_ACC: t_q <= t_q + TW'(1);
        gvi_pkg::S_CEND: begin
          if (maximize ? (mac_acc > best_q) : (mac_acc < best_q)) best_q <= mac_acc;
          c_q <= c_inc;
        end
        gvi_pkg::S_DIFF: begin
          if (rel_q && v_rd_q != 32'd0 && div_sat) diff_q <= 32'hFFFF_FFFF;
          else diff_q <= diff_abs;
        end
        gvi_pkg::S_DIV: if (div_done) diff_q <= quot;
        gvi_pkg::S_UPD: begin
          if (diff_q > largest_q) largest_q <= diff_q;
          s_q <= s_inc;
        end
        default: ;
      endcase
    end
  end

  gvi_mac u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .weight_i (w_rd_q),
    .value_i  (tg_ok ? v_rd_q : 32'd0),
    .acc_o    (mac_acc)
  );

  gvi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .diff_i (diff_abs),
    .old_i  (v_rd_q),
    .done_o (div_done),
    .quot_o (quot)
  );

  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && req_i.cmd == gvi_pkg::CMD_READ |=> done_o && res_o.kind)
    else $error("read request gave no result");

  a_load_no_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && (req_i.cmd == gvi_pkg::CMD_SBOUND || req_i.cmd == gvi_pkg::CMD_TRANS)
    |=> !busy && !done_o)
    else $error("load request stalled the block");

  a_sweeps_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !res_o.kind |-> res_o.sweeps_done != 16'd0 && res_o.sweeps_done <= limit_eff)
    else $error("finished without a valid sweep count");

endmodule

[tb/game_value_iteration_gauss_seidel_tb.sv]
`timescale 1ns / 1ps
// self-checking testbench for the game value iteration block: random games, sweeps and reads
module game_value_iteration_gauss_seidel_tb;

  localparam int NS = gvi_pkg::NUM_STATES_DEF;
  localparam int NC = gvi_pkg::NUM_CHOICES_DEF;
  localparam int NT = gvi_pkg::NUM_TRANSITIONS_DEF;
  localparam longint unsigned ONE_Q = 64'd1 << gvi_pkg::FRAC_BITS;
  localparam int CYCLE_LIMIT = 6000000;
  localparam int ITEM_GOAL = 1350;

  logic          clk_i;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  gvi_pkg::req_t req_i = '0;
  logic          done_o;
  gvi_pkg::res_t res_o;
  logic          cfg_valid_i = 1'b0;
  logic          cfg_ready_o;
  logic [2:0]    cfg_index_i = '0;
  logic [31:0]   cfg_data_i = '0;

  game_value_iteration_gauss_seidel dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .done_o(done_o), .res_o(res_o), .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  // predicted game contents and registers
  logic [12:0] sb_mem[NS+1];
  logic [14:0] cb_mem[NC+1];
  logic [9:0]  tg_mem[NT];
  logic [31:0] wt_mem[NT];
  logic [31:0] val_mem[NS];
  logic        rel_r;
  logic [31:0] prec_r;
  logic [10:0] maxc_r;
  logic [10:0] cnt_r;
  logic [15:0] limit_r;

  // what has been queued so far, -1 for never written
  int plan_sb[NS+1];
  int plan_cb[NC+1];
  int plan_tg[NT];
  bit val_set[NS];

  gvi_pkg::req_t request_q[$];
  gvi_pkg::res_t expected_q[$];
  gvi_pkg::res_t got;
  gvi_pkg::res_t want;
  bit   taken;
  int   idle_pct;
  int   cycles, mismatches, queued_items, n_starts, n_reads, n_conv;

  function automatic longint unsigned choice_sum(int c);
    longint unsigned acc, prod, w, sv;
    int lo, hi;
    lo = int'(cb_mem[c]);
    hi = int'(cb_mem[c+1]);
    if (hi > NT) hi = NT;
    acc = 0;
    for (int t = lo; t < hi; t++) begin
      w = 64'(wt_mem[t]);
      sv = 64'(val_mem[tg_mem[t]]);
      prod = (w * sv) >> gvi_pkg::FRAC_BITS;
      if (prod > ONE_Q) prod = ONE_Q;
      acc += prod;
      if (acc > ONE_Q) acc = ONE_Q;
    end
    return acc;
  endfunction

  function automatic void relax_state(int s, bit maximize, inout longint unsigned largest);
    longint unsigned old, best, v, diff;
    int lo, hi;
    old = 64'(val_mem[s]);
    lo = int'(sb_mem[s]);
    hi = int'(sb_mem[s+1]);
    if (hi > NC) hi = NC;
    best = maximize ? 0 : ONE_Q;
    for (int c = lo; c < hi; c++) begin
      v = choice_sum(c);
      if (maximize ? (v > best) : (v < best)) best = v;
    end
    diff = (best > old) ? best - old : old - best;
    if (rel_r && old != 0) diff = (diff << gvi_pkg::FRAC_BITS) / old;
    if (diff > 64'hFFFF_FFFF) diff = 64'hFFFF_FFFF;
    if (diff > largest) largest = diff;
    val_mem[s] = best[31:0];
  endfunction

  function automatic gvi_pkg::res_t solve_game();
    int maxe, mine, lim, sweeps;
    longint unsigned largest;
    bit conv;
    gvi_pkg::res_t r;
    maxe = (maxc_r > NS) ? NS : int'(maxc_r);
    mine = (cnt_r > NS) ? NS : int'(cnt_r);
    lim = (limit_r == 0) ? 1 : int'(limit_r);
    sweeps = 0;
    do begin
      largest = 0;
      for (int s = 0; s < maxe; s++) relax_state(s, 1'b1, largest);
      for (int s = maxe; s < mine; s++) relax_state(s, 1'b0, largest);
      sweeps++;
      conv = (largest * 2) <= 64'(prec_r);
    end while (!conv && sweeps < lim);
    r = '0;
    r.converged = conv;
    r.sweeps_done = sweeps[15:0];
    return r;
  endfunction

  function automatic bit apply_request(gvi_pkg::req_t q, output gvi_pkg::res_t r);
    r = '0;
    case (q.cmd)
      gvi_pkg::CMD_SBOUND: if (q.index <= NS) sb_mem[q.index] = q.bound[12:0];
      gvi_pkg::CMD_CBOUND: if (q.index <= NC) cb_mem[q.index] = q.bound;
      gvi_pkg::CMD_TRANS: if (q.index < NT) begin
        tg_mem[q.index] = q.target;
        wt_mem[q.index] = q.weight;
      end
      gvi_pkg::CMD_INIT: if (q.index < NS) val_mem[q.index] = q.value;
      gvi_pkg::CMD_START: begin
        r = solve_game();
        return 1'b1;
      end
      gvi_pkg::CMD_READ: begin
        r.kind = 1'b1;
        r.value_out = (q.index < NS) ? val_mem[q.index] : 32'd0;
        return 1'b1;
      end
      default: ;
    endcase
    return 1'b0;
  endfunction

  function automatic void queue_raw(gvi_pkg::req_t q);
    case (q.cmd)
      gvi_pkg::CMD_SBOUND: if (q.index <= NS) plan_sb[q.index] = int'(q.bound[12:0]);
      gvi_pkg::CMD_CBOUND: if (q.index <= NC) plan_cb[q.index] = int'(q.bound);
      gvi_pkg::CMD_TRANS: if (q.index < NT) plan_tg[q.index] = int'(q.target);
      gvi_pkg::CMD_INIT: if (q.index < NS) val_set[q.index] = 1'b1;
      default: ;
    endcase
    request_q.push_back(q);
  endfunction

  function automatic void queue_item(gvi_pkg::cmd_e c, int unsigned idx,
                                     int unsigned bnd = 0, int unsigned tgt = 0,
                                     logic [31:0] wt = '0, logic [31:0] v = '0);
    gvi_pkg::req_t q;
    q.cmd = c;
    q.index = idx[14:0];
    q.bound = bnd[14:0];
    q.target = tgt[9:0];
    q.weight = wt;
    q.value = v;
    queue_raw(q);
    queued_items++;
  endfunction

  // ignored or out-of-range request with random content
  function automatic void queue_noise();
    gvi_pkg::req_t q;
    q.index = 15'($urandom);
    q.bound = 15'($urandom);
    q.target = 10'($urandom);
    q.weight = $urandom;
    q.value = $urandom;
    case ($urandom_range(0, 5))
      0: q.cmd = 3'($urandom_range(6, 7));
      1: begin
        q.cmd = gvi_pkg::CMD_SBOUND;
        q.index = 15'($urandom_range(NS + 1, 32767));
      end
      2: begin
        q.cmd = gvi_pkg::CMD_CBOUND;
        q.index = 15'($urandom_range(NC + 1, 32767));
      end
      3: begin
        q.cmd = gvi_pkg::CMD_TRANS;
        q.index = 15'($urandom_range(NT, 32767));
      end
      4: begin
        q.cmd = gvi_pkg::CMD_INIT;
        q.index = 15'($urandom_range(NS, 32767));
      end
      default: begin
        q.cmd = gvi_pkg::CMD_READ;
        q.index = 15'($urandom_range(NS, 32767));
      end
    endcase
    queue_raw(q);
  endfunction

  // a start may only run over entries that were written
  function automatic bit game_loaded();
    int top, lo, hi, tlo, thi;
    top = (maxc_r > NS) ? NS : int'(maxc_r);
    if (cnt_r > top) top = (cnt_r > NS) ? NS : int'(cnt_r);
    for (int s = 0; s < top; s++) begin
      if (plan_sb[s] < 0 || plan_sb[s+1] < 0 || !val_set[s]) return 1'b0;
      lo = plan_sb[s];
      hi = (plan_sb[s+1] > NC) ? NC : plan_sb[s+1];
      for (int c = lo; c < hi; c++) begin
        if (plan_cb[c] < 0 || plan_cb[c+1] < 0) return 1'b0;
        tlo = plan_cb[c];
        thi = (plan_cb[c+1] > NT) ? NT : plan_cb[c+1];
        for (int t = tlo; t < thi; t++)
          if (plan_tg[t] < 0 || !val_set[plan_tg[t]]) return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic logic [31:0] pick_value();
    return ($urandom_range(0, 1) == 0) ? $urandom_range(0, 32'h8000_0000) : $urandom;
  endfunction

  task automatic write_reg(gvi_pkg::cfg_e idx, logic [31:0] d);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      gvi_pkg::CFG_REL:   rel_r = d[0];
      gvi_pkg::CFG_PREC:  prec_r = d;
      gvi_pkg::CFG_MAXC:  maxc_r = d[10:0];
      gvi_pkg::CFG_CNT:   cnt_r = d[10:0];
      gvi_pkg::CFG_LIMIT: limit_r = d[15:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b0;
  endtask

  task automatic drain();
    do @(posedge clk_i); while (request_q.size() != 0 || start || busy || expected_q.size() != 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_game(int n);
    int cbase, tbase, tgt;
    bit sorted;
    int bnds[$];
    cbase = $urandom_range(0, NC - 5);
    tbase = $urandom_range(0, NT - 9);
    sorted = $urandom_range(0, 3) != 0;
    for (int t = 0; t < 9; t++) begin
      tgt = ($urandom_range(0, 9) == 0) ? NS - 1 : $urandom_range(0, n - 1);
      queue_item(gvi_pkg::CMD_TRANS, tbase + t, 0, tgt,
                 ($urandom_range(0, 3) != 0) ? $urandom_range(0, 32'h2000_0000) : $urandom);
    end
    bnds = {};
    for (int j = 0; j < 5; j++) bnds.push_back(tbase + $urandom_range(0, 8));
    if (sorted) bnds.sort();
    for (int j = 0; j < 5; j++) queue_item(gvi_pkg::CMD_CBOUND, cbase + j, bnds[j]);
    bnds = {};
    for (int j = 0; j <= n; j++) bnds.push_back(cbase + $urandom_range(0, 4));
    if (sorted) bnds.sort();
    for (int j = 0; j <= n; j++) queue_item(gvi_pkg::CMD_SBOUND, j, bnds[j]);
    for (int s = 0; s < n; s++) queue_item(gvi_pkg::CMD_INIT, s, 0, 0, 0, pick_value());
    repeat ($urandom_range(2, 3)) begin
      if (game_loaded()) queue_item(gvi_pkg::CMD_START, 0);
      repeat ($urandom_range(1, 3)) queue_item(gvi_pkg::CMD_READ, $urandom_range(0, n - 1));
      if ($urandom_range(0, 2) == 0) queue_noise();
      if ($urandom_range(0, 3) == 0)
        queue_item(gvi_pkg::CMD_INIT, $urandom_range(0, n - 1), 0, 0, 0, pick_value());
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("game_value_iteration_gauss_seidel verification failed");
      $finish;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        if (apply_request(req_i, got)) expected_q.push_back(got);
        if (req_i.cmd == gvi_pkg::CMD_START) n_starts++;
        if (req_i.cmd == gvi_pkg::CMD_READ) n_reads++;
      end
      if (taken || !start) begin
        if (request_q.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
          start <= 1'b1;
          req_i <= request_q.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", res_o);
      end else begin
        want = expected_q.pop_front();
        if (want.kind == 1'b0 && want.converged) n_conv++;
        if (res_o.kind !== want.kind || res_o.value_out !== want.value_out ||
            res_o.converged !== want.converged || res_o.sweeps_done !== want.sweeps_done) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %p actual %p", want, res_o);
        end
      end
    end
  end

  initial begin
    int phase, n;
    foreach (plan_sb[i]) plan_sb[i] = -1;
    foreach (plan_cb[i]) plan_cb[i] = -1;
    foreach (plan_tg[i]) plan_tg[i] = -1;
    rel_r = 1'b0;
    prec_r = gvi_pkg::PREC_RST;
    maxc_r = '0;
    cnt_r = '0;
    limit_r = gvi_pkg::LIMIT_RST;
    idle_pct = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // saturating sums, cut ranges, empty minimizer state, out-of-range and unused requests
    write_reg(gvi_pkg::CFG_MAXC, 32'd1);
    write_reg(gvi_pkg::CFG_CNT, 32'd2);
    queue_item(gvi_pkg::CMD_INIT, NS - 1, 0, 0, 0, 32'h8000_0000);
    queue_item(gvi_pkg::CMD_INIT, 0, 0, 0, 0, 32'hFFFF_FFFF);
    queue_item(gvi_pkg::CMD_INIT, 1, 0, 0, 0, 32'd0);
    queue_item(gvi_pkg::CMD_TRANS, NT - 2, 0, NS - 1, 32'h8000_0000);
    queue_item(gvi_pkg::CMD_TRANS, NT - 1, 0, 0, 32'hFFFF_FFFF);
    queue_item(gvi_pkg::CMD_CBOUND, NC - 1, NT - 2);
    queue_item(gvi_pkg::CMD_CBOUND, NC, 32767);
    queue_item(gvi_pkg::CMD_SBOUND, 0, NC - 1);
    queue_item(gvi_pkg::CMD_SBOUND, 1, 32767);
    queue_item(gvi_pkg::CMD_SBOUND, 2, 0);
    queue_item(gvi_pkg::CMD_START, 0);
    queue_item(gvi_pkg::CMD_READ, 0);
    queue_item(gvi_pkg::CMD_READ, 1);
    queue_item(gvi_pkg::CMD_READ, NS - 1);
    queue_item(gvi_pkg::CMD_READ, 32767);
    repeat (6) queue_noise();
    queue_item(gvi_pkg::CMD_START, 0);
    queue_item(gvi_pkg::CMD_READ, 0);

    phase = 0;
    while (queued_items < ITEM_GOAL) begin
      drain();
      case (phase % 3)
        0: idle_pct = 0;
        1: idle_pct = 81;
        default: idle_pct = 8;
      endcase
      if (phase % 7 == 6) begin
        // largest counts and limits: loads and reads only
        write_reg(gvi_pkg::CFG_MAXC, 32'h7FF);
        write_reg(gvi_pkg::CFG_CNT, 32'h7FF);
        write_reg(gvi_pkg::CFG_LIMIT, 32'hFFFF);
        write_reg(gvi_pkg::CFG_PREC, 32'hFFFF_FFFF);
        repeat (4) queue_item(gvi_pkg::CMD_READ, $urandom_range(0, 1));
        repeat (3) queue_noise();
      end else begin
        n = $urandom_range(1, 6);
        write_reg(gvi_pkg::CFG_REL, $urandom_range(0, 1));
        case ($urandom_range(0, 4))
          0: write_reg(gvi_pkg::CFG_PREC, 32'd0);
          1: write_reg(gvi_pkg::CFG_PREC, 32'h8000_0000);
          2: write_reg(gvi_pkg::CFG_PREC, 32'hFFFF_FFFF);
          3: write_reg(gvi_pkg::CFG_PREC, $urandom_range(0, 32'h0010_0000));
          default: write_reg(gvi_pkg::CFG_PREC, $urandom);
        endcase
        write_reg(gvi_pkg::CFG_CNT, ($urandom_range(0, 3) != 0) ? n : $urandom_range(0, n));
        write_reg(gvi_pkg::CFG_MAXC, $urandom_range(0, n));
        write_reg(gvi_pkg::CFG_LIMIT, ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1)
                                                                 : $urandom_range(2, 10));
        run_game(n);
      end
      phase++;
    end
    drain();

    $display("covered %0d requests in %0d phases: %0d sweep runs (%0d converged), %0d reads",
             queued_items, phase + 1, n_starts, n_conv, n_reads);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("game_value_iteration_gauss_seidel verification clean");
    end else begin
      $display("game_value_iteration_gauss_seidel verification failed");
    end
    $finish;
  end

endmodule
